// File: rtl/dc_pkg.sv
// Shared types and constants for the scaled decimal comparator.
// Used by dc_cell and decimal_compare; depends on nothing else.
`default_nettype none

package dc_pkg;

  // Magnitude width and largest scale that still allows a multiply step
  localparam int MAG_BITS  = 96;
  localparam int MAX_SCALE = 28;
  localparam int SCALE_W   = 5;

  // Each cell holds one 32-bit limb of each operand
  localparam int CELL_W  = 32;
  localparam int N_CELLS = (MAG_BITS + CELL_W - 1) / CELL_W;
  localparam int VEC_W   = N_CELLS * CELL_W;

  // Divide counter spans the divide steps plus the drain down the chain
  localparam int DCNT_W = $clog2(32 + N_CELLS);

  // Divide by ten: 2^32 = 10 * LIMB_DIV + 6, low part by reciprocal
  localparam logic [31:0] LIMB_DIV  = 32'd429496729;
  localparam logic [34:0] DIV_MAGIC = 35'd27487790695;
  localparam int          DIV_SHIFT = 38;

  // Result codes
  localparam logic [1:0] REL_LESS    = 2'd0;
  localparam logic [1:0] REL_EQUAL   = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  // Remainder beat handed from a cell to the cell below
  typedef struct packed {
    logic       v;
    logic [3:0] rem;
  } tok_t;

  // Per-cycle controls broadcast to every cell
  typedef struct packed {
    logic load;
    logic mul_en;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/decimal_compare.sv
// Top level of the scaled decimal comparator: controller, a chain of
// dc_cell limb cells and the result register. Depends on dc_pkg and dc_cell.
//
//   channel | handshake          | payload
//   input   | in_valid, in_stall | a_mag_low/high, a_scale, a_negative, b_*
//   output  | out_valid, out_stall | relation
//
// An item takes m multiply-by-ten steps (carry rippled across the cells) and d
// divide-by-ten steps fed into the top cell one per cycle and draining down
// the chain of three cells; m + d never exceeds 31. Reset clears control only;
// no clearing pass. A waiting result does not block the next input beat.
`default_nettype none

module decimal_compare (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] a_mag_low,
  input  wire logic [31:0] a_mag_high,
  input  wire logic [4:0]  a_scale,
  input  wire logic        a_negative,
  input  wire logic [63:0] b_mag_low,
  input  wire logic [31:0] b_mag_high,
  input  wire logic [4:0]  b_scale,
  input  wire logic        b_negative,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       relation
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state;
  logic [dc_pkg::SCALE_W-1:0] s_small;
  logic [dc_pkg::SCALE_W-1:0] s_big;
  logic [dc_pkg::DCNT_W-1:0]  dcnt;
  logic big_is_a;
  logic neg_a;
  logic neg_b;

  logic accept;
  dc_pkg::ctrl_t ctrl;
  logic [dc_pkg::VEC_W-1:0] a_vec_in, b_vec_in, small_in, big_in;
  logic [dc_pkg::VEC_W-1:0] small_vec, big_vec, mul_vec, a_vec, b_vec;
  logic [3:0] carry [dc_pkg::N_CELLS+1];
  dc_pkg::tok_t tok [dc_pkg::N_CELLS+1];
  logic mul_go, fits, top_ok;
  logic mag_eq, mag_gt, greater;
  logic [1:0] rel_next;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // Load magnitudes, dropping bits above the magnitude width
  assign a_vec_in = dc_pkg::VEC_W'(dc_pkg::MAG_BITS'({a_mag_high, a_mag_low}));
  assign b_vec_in = dc_pkg::VEC_W'(dc_pkg::MAG_BITS'({b_mag_high, b_mag_low}));
  assign small_in = (a_scale > b_scale) ? b_vec_in : a_vec_in;
  assign big_in   = (a_scale > b_scale) ? a_vec_in : b_vec_in;

  // Multiply step test across the whole word
  assign top_ok = (small_vec >> (dc_pkg::MAG_BITS - 3)) == '0;
  assign fits   = (carry[dc_pkg::N_CELLS] == 4'd0) && ((mul_vec >> dc_pkg::MAG_BITS) == '0);
  assign mul_go = (state == ST_MUL) && (s_small != s_big) && top_ok &&
                  (s_small <= dc_pkg::SCALE_W'(dc_pkg::MAX_SCALE)) && fits;

  assign ctrl.load   = accept;
  assign ctrl.mul_en = mul_go;

  // Feed remainder beats into the top cell
  assign carry[0] = 4'd0;
  assign tok[dc_pkg::N_CELLS].v   = (state == ST_DIV) &&
                                    (dcnt > dc_pkg::DCNT_W'(dc_pkg::N_CELLS - 1));
  assign tok[dc_pkg::N_CELLS].rem = 4'd0;

  // Chain of limb cells, limb 0 at the bottom
  for (genvar k = 0; k < dc_pkg::N_CELLS; k++) begin : g_cell
    dc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .small_in   (small_in[k*dc_pkg::CELL_W +: dc_pkg::CELL_W]),
      .big_in     (big_in[k*dc_pkg::CELL_W +: dc_pkg::CELL_W]),
      .carry_in   (carry[k]),
      .carry_out  (carry[k+1]),
      .mul_limb   (mul_vec[k*dc_pkg::CELL_W +: dc_pkg::CELL_W]),
      .tok_in     (tok[k+1]),
      .tok_out    (tok[k]),
      .small_limb (small_vec[k*dc_pkg::CELL_W +: dc_pkg::CELL_W]),
      .big        (big_vec[k*dc_pkg::CELL_W +: dc_pkg::CELL_W])
    );
  end

  // Compare aligned magnitudes and apply signs
  assign a_vec  = big_is_a ? big_vec : small_vec;
  assign b_vec  = big_is_a ? small_vec : big_vec;
  assign mag_eq = (a_vec == b_vec);
  assign mag_gt = (a_vec > b_vec);

  always_comb begin
    if (neg_a && !neg_b) begin
      greater = 1'b0;
    end else if (!neg_a && neg_b) begin
      greater = 1'b1;
    end else if (neg_a) begin
      greater = !mag_gt && !mag_eq;
    end else begin
      greater = mag_gt;
    end
    if (mag_eq && (neg_a == neg_b)) begin
      rel_next = dc_pkg::REL_EQUAL;
    end else if (greater) begin
      rel_next = dc_pkg::REL_GREATER;
    end else begin
      rel_next = dc_pkg::REL_LESS;
    end
  end

  // Sequence multiply, divide and result load
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise a new result beat, or drop the one just taken
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!mul_go) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scales, signs, divide counter and result
  always_ff @(posedge clk) begin
    if (accept) begin
      big_is_a <= (a_scale > b_scale);
      s_small  <= (a_scale > b_scale) ? b_scale : a_scale;
      s_big    <= (a_scale > b_scale) ? a_scale : b_scale;
      neg_a    <= a_negative;
      neg_b    <= b_negative;
    end
    if (mul_go) begin
      s_small <= s_small + 1'b1;
    end
    if (state == ST_MUL && !mul_go) begin
      dcnt <= dc_pkg::DCNT_W'(s_big - s_small) + dc_pkg::DCNT_W'(dc_pkg::N_CELLS - 1);
    end else if (state == ST_DIV && dcnt != '0) begin
      dcnt <= dcnt - 1'b1;
    end
    if (state == ST_DONE && (!out_valid || !out_stall)) begin
      relation <= rel_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dc_cell.sv
// One limb cell: holds a 32-bit limb of the small and big operands.
// Multiplies its small limb by ten with a rippled carry and divides its big
// limb by ten on a remainder beat from above. Depends on dc_pkg.
`default_nettype none

module dc_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dc_pkg::ctrl_t        ctrl,
  input  wire logic [31:0]          small_in,
  input  wire logic [31:0]          big_in,
  input  wire logic [3:0]           carry_in,
  output logic      [3:0]           carry_out,
  output logic      [31:0]          mul_limb,
  input  wire dc_pkg::tok_t         tok_in,
  output dc_pkg::tok_t              tok_out,
  output logic      [31:0]          small_limb,
  output logic      [31:0]          big
);

  logic [35:0] mul_full;
  logic [5:0]  rem6;
  logic [32:0] n;
  logic [67:0] qprod;
  logic [31:0] q_low;
  logic [31:0] q;
  logic [32:0] back;

  // Times ten plus carry from the cell below
  assign mul_full  = ({4'b0, small_limb} << 3) + ({4'b0, small_limb} << 1) +
                     {32'b0, carry_in};
  assign carry_out = mul_full[35:32];
  assign mul_limb  = mul_full[31:0];

  // Divide (rem * 2^32 + big) by ten
  assign rem6  = 6'(tok_in.rem) * 6'd6;
  assign n     = {1'b0, big} + {27'b0, rem6};
  assign qprod = 68'(n) * 68'(dc_pkg::DIV_MAGIC);
  assign q_low = 32'(qprod[67:dc_pkg::DIV_SHIFT]);
  assign q     = 32'({28'b0, tok_in.rem} * dc_pkg::LIMB_DIV) + q_low;
  assign back  = 33'(q_low) * 33'd10;

  // Update limbs
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      small_limb <= small_in;
      big        <= big_in;
    end else begin
      if (ctrl.mul_en) begin
        small_limb <= mul_limb;
      end
      if (tok_in.v) begin
        big <= q;
      end
    end
  end

  // Pass the remainder beat down
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.v <= 1'b0;
    end else begin
      tok_out.v <= tok_in.v && !ctrl.load;
    end
    tok_out.rem <= 4'(n - back);
  end

endmodule

`default_nettype wire
